>>> sv/stt_pkg.sv
package stt_pkg;

	typedef enum logic [3:0] {
		SM_IDLE,
		SM_IDENT,
		SM_STRING,
		SM_ESC,
		SM_ZERO,
		SM_HEX,
		SM_DEC,
		SM_COMMENT,
		SM_PEND
	} mode_t;

	localparam logic [5:0] K_END     = 6'd0;
	localparam logic [5:0] K_ILLEGAL = 6'd1;
	localparam logic [5:0] K_IDENT   = 6'd2;
	localparam logic [5:0] K_STRING  = 6'd3;
	localparam logic [5:0] K_NUMBER  = 6'd4;
	localparam logic [5:0] K_KW_BASE = 6'd5;
	localparam logic [5:0] K_AT      = 6'd17;
	localparam logic [5:0] K_COMMA   = 6'd18;
	localparam logic [5:0] K_ASSIGN  = 6'd19;
	localparam logic [5:0] K_EQ      = 6'd20;
	localparam logic [5:0] K_OR      = 6'd21;
	localparam logic [5:0] K_OROR    = 6'd22;
	localparam logic [5:0] K_AND     = 6'd23;
	localparam logic [5:0] K_ANDAND  = 6'd24;
	localparam logic [5:0] K_LT      = 6'd25;
	localparam logic [5:0] K_LE      = 6'd26;
	localparam logic [5:0] K_GT      = 6'd27;
	localparam logic [5:0] K_GE      = 6'd28;
	localparam logic [5:0] K_DOT     = 6'd29;
	localparam logic [5:0] K_DOTDOT  = 6'd30;
	localparam logic [5:0] K_LBRACE  = 6'd31;
	localparam logic [5:0] K_RBRACE  = 6'd32;
	localparam logic [5:0] K_LBRACK  = 6'd33;
	localparam logic [5:0] K_RBRACK  = 6'd34;
	localparam logic [5:0] K_LPAREN  = 6'd35;
	localparam logic [5:0] K_RPAREN  = 6'd36;
	localparam logic [5:0] K_PLUS    = 6'd37;
	localparam logic [5:0] K_MINUS   = 6'd38;
	localparam logic [5:0] K_STAR    = 6'd39;
	localparam logic [5:0] K_SLASH   = 6'd40;
	localparam logic [5:0] K_CARET   = 6'd41;
	localparam logic [5:0] K_PERCENT = 6'd42;
	localparam logic [5:0] K_COLON   = 6'd43;
	localparam logic [5:0] K_QUEST   = 6'd44;
	localparam logic [5:0] K_BANG    = 6'd45;
	localparam logic [5:0] K_NE      = 6'd46;

	localparam int NUM_KW = 12;
	localparam logic [47:0] KW_TEXT [NUM_KW] = '{
		48'h737472756374, 48'h72657475726E, 48'h666E, 48'h6966,
		48'h656C7365, 48'h666F72, 48'h74797065, 48'h63617374,
		48'h636F6E7374, 48'h726566, 48'h656E756D, 48'h7573696E67
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{
		3'd6, 3'd6, 3'd2, 3'd2, 3'd4, 3'd3, 3'd4, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5
	};

	// widest field widths; the top level trims to its parameters
	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] line;
		logic [31:0] column;
		logic        first;
		logic [39:0] offset;
		logic [31:0] length;
		logic [63:0] value;
		logic        is_bin;
		logic [2:0]  prec;
		logic        last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_word(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == "_";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// bit 4 flags a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (is_digit(c)) r = {1'b1, 4'(c - "0")};
		else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
		return r;
	endfunction

	function automatic logic [2:0] prec_of(input logic [5:0] k);
		logic [2:0] r;
		case (k)
			K_OROR: r = 3'd1;
			K_ANDAND: r = 3'd2;
			K_EQ, K_LT, K_LE, K_GT, K_GE, K_NE: r = 3'd3;
			K_PLUS, K_MINUS, K_AND, K_OR: r = 3'd4;
			K_STAR, K_SLASH, K_PERCENT: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		logic [5:0] r;
		case (c)
			"@": r = K_AT;
			",": r = K_COMMA;
			"{": r = K_LBRACE;
			"}": r = K_RBRACE;
			"[": r = K_LBRACK;
			"]": r = K_RBRACK;
			"(": r = K_LPAREN;
			")": r = K_RPAREN;
			"+": r = K_PLUS;
			"-": r = K_MINUS;
			"*": r = K_STAR;
			"^": r = K_CARET;
			"%": r = K_PERCENT;
			":": r = K_COLON;
			"?": r = K_QUEST;
			default: r = K_ILLEGAL;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] lone_kind(input logic [7:0] p);
		logic [5:0] r;
		case (p)
			"=": r = K_ASSIGN;
			"|": r = K_OR;
			"&": r = K_AND;
			"<": r = K_LT;
			">": r = K_GT;
			".": r = K_DOT;
			"/": r = K_SLASH;
			default: r = K_BANG;
		endcase
		return r;
	endfunction

	// K_END means no pair
	function automatic logic [5:0] pair_kind(input logic [7:0] p, input logic [7:0] c);
		logic [5:0] r;
		r = K_END;
		if (p == "=" && c == "=") r = K_EQ;
		else if (p == "|" && c == "|") r = K_OROR;
		else if (p == "&" && c == "&") r = K_ANDAND;
		else if (p == "<" && c == "=") r = K_LE;
		else if (p == ">" && c == "=") r = K_GE;
		else if (p == "." && c == ".") r = K_DOTDOT;
		else if (p == "!" && c == "=") r = K_NE;
		return r;
	endfunction

endpackage

>>> sv/stt_scan.sv
module stt_scan #(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 24,
	parameter int LENGTH_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          text_byte,
	output stt_pkg::token_t     tok0,
	output stt_pkg::token_t     tok1,
	output logic [1:0]          tok_count
);

	localparam logic [LINE_BITS-1:0]   LINE_MAX   = '1;
	localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

	stt_pkg::mode_t           mode_q, mode_d;
	logic [7:0]               pend_q, pend_d;
	logic [47:0]              kw_q, kw_d;
	logic [LINE_BITS-1:0]     line_q, line_d, sline_q, sline_d;
	logic [COLUMN_BITS-1:0]   col_q, col_d, scol_q, scol_d;
	logic [OFFSET_BITS-1:0]   off_q, off_d, soff_q, soff_d;
	logic [LENGTH_BITS-1:0]   len_q, len_d;
	logic                     nls_q, nls_d;
	logic [63:0]              hex_q, hex_d;

	function automatic stt_pkg::token_t mk_tok(
		input logic [5:0] kind, input logic [63:0] val, input logic bin,
		input logic [LINE_BITS-1:0] sl, input logic [COLUMN_BITS-1:0] sc,
		input logic [OFFSET_BITS-1:0] so, input logic [LENGTH_BITS-1:0] ln,
		input logic nls);
		stt_pkg::token_t t;
		t.kind   = kind;
		t.line   = 32'((sl == LINE_MAX) ? sl : sl + 1'b1);
		t.column = 32'(sc);
		t.first  = nls || (kind == stt_pkg::K_RBRACE);
		t.offset = 40'(so);
		t.length = 32'(ln);
		t.value  = val;
		t.is_bin = bin;
		t.prec   = stt_pkg::prec_of(kind);
		t.last   = 1'b0;
		return t;
	endfunction

	always_comb begin
		stt_pkg::token_t t [2];
		logic [1:0] n;
		logic again, nl, ended;
		logic [5:0] k;
		logic [4:0] h;
		t[0] = '0;
		t[1] = '0;
		n = 2'd0;
		again = 1'b0;
		nl = 1'b0;
		ended = 1'b0;
		k = stt_pkg::K_END;
		h = 5'd0;
		mode_d = mode_q;
		pend_d = pend_q;
		kw_d = kw_q;
		line_d = line_q;
		col_d = col_q;
		off_d = off_q;
		sline_d = sline_q;
		scol_d = scol_q;
		soff_d = soff_q;
		len_d = len_q;
		nls_d = nls_q;
		hex_d = hex_q;
		for (int p = 0; p < 2; p++) begin
			if (p == 0 || again) begin
				again = 1'b0;
				case (mode_d)
					stt_pkg::SM_IDLE: begin
						if (text_byte == 8'd0) begin
							sline_d = line_q; scol_d = col_q; soff_d = off_q;
							len_d = '0;
							t[n[0]] = mk_tok(stt_pkg::K_END, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							ended = 1'b1;
						end else if (stt_pkg::is_space(text_byte)) begin
							if (text_byte == 8'd10) begin
								nls_d = 1'b1;
								nl = 1'b1;
							end
						end else if (text_byte == "'") begin
							sline_d = line_q; scol_d = col_q;
							soff_d = (off_q == OFFSET_MAX) ? off_q : off_q + 1'b1;
							len_d = '0;
							mode_d = stt_pkg::SM_STRING;
						end else begin
							sline_d = line_q; scol_d = col_q; soff_d = off_q;
							len_d = LENGTH_BITS'(1);
							if (stt_pkg::is_alpha(text_byte) || text_byte == "_") begin
								kw_d = 48'(text_byte);
								mode_d = stt_pkg::SM_IDENT;
							end else if (text_byte == "0") begin
								mode_d = stt_pkg::SM_ZERO;
							end else if (stt_pkg::is_digit(text_byte)) begin
								mode_d = stt_pkg::SM_DEC;
							end else if (text_byte == "=" || text_byte == "|" ||
								text_byte == "&" || text_byte == "<" ||
								text_byte == ">" || text_byte == "!" ||
								text_byte == "." || text_byte == "/") begin
								pend_d = text_byte;
								mode_d = stt_pkg::SM_PEND;
							end else begin
								t[n[0]] = mk_tok(stt_pkg::single_kind(text_byte), 64'd0,
									1'b0, sline_d, scol_d, soff_d, len_d, nls_d);
								nls_d = 1'b0; n = n + 2'd1;
							end
						end
					end
					stt_pkg::SM_IDENT: begin
						if (stt_pkg::is_word(text_byte)) begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							kw_d = {kw_d[39:0], text_byte};
						end else begin
							k = stt_pkg::K_IDENT;
							for (int i = stt_pkg::NUM_KW - 1; i >= 0; i--) begin
								if (len_d == LENGTH_BITS'(stt_pkg::KW_LEN[i]) &&
									kw_d == stt_pkg::KW_TEXT[i])
									k = stt_pkg::K_KW_BASE + 6'(i);
							end
							t[n[0]] = mk_tok(k, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end
					end
					stt_pkg::SM_STRING: begin
						if (text_byte == "'") begin
							t[n[0]] = mk_tok(stt_pkg::K_STRING, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE;
						end else if (text_byte == 8'd0) begin
							t[n[0]] = mk_tok(stt_pkg::K_ILLEGAL, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end else begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							if (text_byte == "\\") mode_d = stt_pkg::SM_ESC;
						end
					end
					stt_pkg::SM_ESC: begin
						if (text_byte == "\\" || text_byte == "t" || text_byte == "'" ||
							text_byte == "n" || text_byte == "3") begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							mode_d = stt_pkg::SM_STRING;
						end else begin
							t[n[0]] = mk_tok(stt_pkg::K_ILLEGAL, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end
					end
					stt_pkg::SM_ZERO: begin
						if (text_byte == "x") begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							hex_d = 64'd0;
							mode_d = stt_pkg::SM_HEX;
						end else if (stt_pkg::is_digit(text_byte) || text_byte == ".") begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							mode_d = stt_pkg::SM_DEC;
						end else begin
							t[n[0]] = mk_tok(stt_pkg::K_NUMBER, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end
					end
					stt_pkg::SM_HEX: begin
						h = stt_pkg::hex_digit(text_byte);
						if (h[4]) begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							hex_d = (hex_d[63:60] != 4'd0) ? '1 : {hex_d[59:0], h[3:0]};
						end else begin
							t[n[0]] = mk_tok(stt_pkg::K_NUMBER, hex_d, 1'b1,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end
					end
					stt_pkg::SM_DEC: begin
						if (stt_pkg::is_digit(text_byte) || text_byte == ".") begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
						end else begin
							t[n[0]] = mk_tok(stt_pkg::K_NUMBER, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end
					end
					stt_pkg::SM_COMMENT: begin
						if (text_byte == 8'd0 || text_byte == 8'd10 || text_byte == 8'd13) begin
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end
					end
					stt_pkg::SM_PEND: begin
						k = stt_pkg::pair_kind(pend_d, text_byte);
						if (pend_d == "/" && text_byte == "/") begin
							nls_d = 1'b0;
							mode_d = stt_pkg::SM_COMMENT;
						end else if (pend_d == "." && stt_pkg::is_digit(text_byte)) begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							mode_d = stt_pkg::SM_DEC;
						end else if (k != stt_pkg::K_END) begin
							len_d = (len_d == LENGTH_MAX) ? len_d : len_d + 1'b1;
							t[n[0]] = mk_tok(k, 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE;
						end else begin
							t[n[0]] = mk_tok(stt_pkg::lone_kind(pend_d), 64'd0, 1'b0,
								sline_d, scol_d, soff_d, len_d, nls_d);
							nls_d = 1'b0; n = n + 2'd1;
							mode_d = stt_pkg::SM_IDLE; again = 1'b1;
						end
					end
					default: begin
						mode_d = stt_pkg::SM_IDLE; again = 1'b1;
					end
				endcase
			end
		end
		if (ended) begin
			line_d = '0; col_d = '0; off_d = '0;
			nls_d = 1'b0;
			mode_d = stt_pkg::SM_IDLE;
		end else if (nl) begin
			line_d = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
			col_d = '0;
			off_d = (off_q == OFFSET_MAX) ? off_q : off_q + 1'b1;
		end else begin
			col_d = (col_q == COLUMN_MAX) ? col_q : col_q + 1'b1;
			off_d = (off_q == OFFSET_MAX) ? off_q : off_q + 1'b1;
		end
		if (n == 2'd1) t[0].last = 1'b1;
		if (n == 2'd2) t[1].last = 1'b1;
		tok0 = t[0];
		tok1 = t[1];
		tok_count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= stt_pkg::SM_IDLE;
			pend_q <= '0;
			kw_q <= '0;
			line_q <= '0;
			col_q <= '0;
			off_q <= '0;
			sline_q <= '0;
			scol_q <= '0;
			soff_q <= '0;
			len_q <= '0;
			nls_q <= 1'b0;
			hex_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			pend_q <= pend_d;
			kw_q <= kw_d;
			line_q <= line_d;
			col_q <= col_d;
			off_q <= off_d;
			sline_q <= sline_d;
			scol_q <= scol_d;
			soff_q <= soff_d;
			len_q <= len_d;
			nls_q <= nls_d;
			hex_q <= hex_d;
		end
	end

endmodule

>>> sv/source_text_tokenizer_core.sv
// streaming tokenizer: one source byte per word on the text channel, where a 0 byte ends
// the text and resets line, column and offset for the next one; each byte gives zero, one
// or two tokens on the token channel, last marking the final token of a byte.
// a byte is scanned in the cycle it is taken and its tokens go into a four-deep token
// queue, so the block takes one byte every cycle while fewer than three tokens are queued;
// the queue drains one token per cycle while token_ready is high, pacing token-dense text.
// the user must write source_id via cfg_we/cfg_wdata only while idle; it is not enforced.
module source_text_tokenizer_core #(
	parameter int LINE_BITS   = 20,
	parameter int COLUMN_BITS = 16,
	parameter int OFFSET_BITS = 24,
	parameter int LENGTH_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [15:0]            cfg_wdata,
	input  logic                   text_valid,
	output logic                   text_ready,
	input  logic [7:0]             text_byte,
	output logic                   token_valid,
	input  logic                   token_ready,
	output logic [5:0]             token_kind,
	output logic [LINE_BITS-1:0]   token_line,
	output logic [COLUMN_BITS-1:0] token_column,
	output logic                   first_on_line,
	output logic [OFFSET_BITS-1:0] text_offset,
	output logic [LENGTH_BITS-1:0] text_length,
	output logic [63:0]            binary_value,
	output logic                   value_is_binary,
	output logic [2:0]             precedence,
	output logic [15:0]            source_number,
	output logic                   last
);

	logic [15:0]      source_id_q;
	stt_pkg::token_t  tok0, tok1, head;
	logic [1:0]       tok_count;
	stt_pkg::token_t  queue_q [4];
	logic [1:0]       wp_q, rp_q;
	logic [2:0]       cnt_q;
	logic             take, pop;

	// room for the two tokens a byte can make
	assign text_ready = (cnt_q <= 3'd2);
	assign take = text_valid && text_ready;
	assign token_valid = (cnt_q != 3'd0);
	assign pop = token_valid && token_ready;

	stt_scan #(
		.LINE_BITS(LINE_BITS),
		.COLUMN_BITS(COLUMN_BITS),
		.OFFSET_BITS(OFFSET_BITS),
		.LENGTH_BITS(LENGTH_BITS)
	) u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.text_byte(text_byte),
		.tok0(tok0),
		.tok1(tok1),
		.tok_count(tok_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_id_q <= '0;
		end else if (cfg_we) begin
			source_id_q <= cfg_wdata;
		end
	end

	// token queue payload, no reset needed
	always_ff @(posedge clk) begin
		if (take && tok_count != 2'd0) queue_q[wp_q] <= tok0;
		if (take && tok_count == 2'd2) queue_q[wp_q + 2'd1] <= tok1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (take) wp_q <= wp_q + tok_count;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + (take ? 3'(tok_count) : 3'd0) - (pop ? 3'd1 : 3'd0);
		end
	end

	assign head = queue_q[rp_q];
	assign token_kind = head.kind;
	assign token_line = head.line[LINE_BITS-1:0];
	assign token_column = head.column[COLUMN_BITS-1:0];
	assign first_on_line = head.first;
	assign text_offset = head.offset[OFFSET_BITS-1:0];
	assign text_length = head.length[LENGTH_BITS-1:0];
	assign binary_value = head.value;
	assign value_is_binary = head.is_bin;
	assign precedence = head.prec;
	assign source_number = source_id_q;
	assign last = head.last;

`ifndef SYNTH
	// queue never overfills
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("token queue overflow");

	// an end-of-text byte always yields a token
	a_end_token: assert property (@(posedge clk) disable iff (!arst_n)
		(take && text_byte == 8'd0) |=> token_valid)
		else $error("no token after end of text");

	// a non-final token always has its sibling queued behind it
	a_sibling: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && !last) |-> (cnt_q >= 3'd2))
		else $error("first token of a pair queued alone");
`endif

endmodule
